@@ hdl/rsvu_pkg.sv @@
// Shared types and constants for the replica state vector update unit.
`timescale 1ns / 1ps
package rsvu_pkg;

    localparam int STATE_BYTES_DEF = 8;
    localparam int SLOTS_MAX       = 32;
    localparam int VEC_W           = 2 * SLOTS_MAX;

    localparam logic [1:0] ST_INACTIVE = 2'd0;
    localparam logic [1:0] ST_OLD      = 2'd1;
    localparam logic [1:0] ST_TOO_OLD  = 2'd2;
    localparam logic [1:0] ST_ACTIVE   = 2'd3;

    localparam logic ACT_MARK = 1'b0;
    localparam logic ACT_WALK = 1'b1;

    typedef struct packed {
        logic              action;
        logic [VEC_W-1:0]  states_in;
        logic [4:0]        writer_slot;
        logic [2:0]        map_inactive;
        logic [2:0]        map_old;
        logic [2:0]        map_too_old;
        logic [2:0]        map_active;
        logic [7:0]        report_table;
        logic              stop_at_first;
    } t_item;

    typedef struct packed {
        logic [VEC_W-1:0]  states_out;
        logic [1:0]        report_code;
        logic              changed;
        logic              gen_bump;
    } t_result;

    typedef struct packed {
        logic action;
        logic is_writer;
        logic en;
    } t_slot_ctl;

    typedef struct packed {
        logic [2:0] map_inactive;
        logic [2:0] map_old;
        logic [2:0] map_too_old;
        logic [2:0] map_active;
    } t_map;

endpackage

@@ hdl/rsvu_slot.sv @@
// Rewrite logic for one replica state slot.
`timescale 1ns / 1ps
module rsvu_slot (
    input  logic [1:0]          i_state,
    input  rsvu_pkg::t_slot_ctl i_ctl,
    input  rsvu_pkg::t_map      i_map,
    input  logic [7:0]          i_table,
    output logic [1:0]          o_state,
    output logic [1:0]          o_code,
    output logic                o_changed,
    output logic                o_demote
);
    import rsvu_pkg::*;

    logic [2:0] map_sel;
    logic [1:0] ns;
    logic       dem;

    always_comb begin
        case (i_state)
            ST_INACTIVE: map_sel = i_map.map_inactive;
            ST_OLD:      map_sel = i_map.map_old;
            ST_TOO_OLD:  map_sel = i_map.map_too_old;
            default:     map_sel = i_map.map_active;
        endcase
    end

    always_comb begin
        o_code = i_table[2*i_state +: 2];
    end

    always_comb begin
        ns  = i_state;
        dem = 1'b0;
        if (i_ctl.action == ACT_MARK) begin
            if (i_ctl.is_writer) begin
                ns = ST_ACTIVE;
            end else if (i_state == ST_ACTIVE) begin
                ns  = ST_OLD;
                dem = 1'b1;
            end else if (i_state == ST_OLD) begin
                ns = ST_TOO_OLD;
            end
        end else if (!map_sel[2]) begin
            ns = map_sel[1:0];
        end
        if (!i_ctl.en) begin
            ns  = i_state;
            dem = 1'b0;
        end
    end

    assign o_state   = ns;
    assign o_changed = (ns != i_state);
    assign o_demote  = dem;

endmodule

@@ hdl/rsvu_core.sv @@
// Combinational update of the whole state vector from one registered item.
`timescale 1ns / 1ps
module rsvu_core #(
    parameter int STATE_BYTES = rsvu_pkg::STATE_BYTES_DEF
) (
    input  rsvu_pkg::t_item   i_item,
    output rsvu_pkg::t_result o_result
);
    import rsvu_pkg::*;

    localparam int SLOTS = (4 * STATE_BYTES > SLOTS_MAX) ? SLOTS_MAX : 4 * STATE_BYTES;

    t_map                 map;
    logic [SLOTS_MAX-1:0] hit;
    logic [SLOTS_MAX-1:0] hit_rev;
    logic [SLOTS_MAX-1:0] first_hit;
    logic [SLOTS_MAX-1:0] last_rev;
    logic [SLOTS_MAX-1:0] last_hit;
    logic [SLOTS_MAX-1:0] below_first;
    logic [SLOTS_MAX-1:0] en_mask;
    logic [SLOTS_MAX-1:0] sel;
    logic [SLOTS_MAX-1:0] chg;
    logic [SLOTS_MAX-1:0] dem;
    logic [1:0]           code [SLOTS_MAX];
    logic [VEC_W-1:0]     states;
    logic [1:0]           report;
    logic                 is_walk;

    assign map.map_inactive = i_item.map_inactive;
    assign map.map_old      = i_item.map_old;
    assign map.map_too_old  = i_item.map_too_old;
    assign map.map_active   = i_item.map_active;
    assign is_walk          = (i_item.action == ACT_WALK);

    always_comb begin
        for (int k = 0; k < SLOTS_MAX; k++) begin
            hit_rev[k]  = hit[SLOTS_MAX-1-k];
            last_hit[k] = last_rev[SLOTS_MAX-1-k];
        end
    end

    assign first_hit   = hit & (~hit + 1'b1);
    assign last_rev    = hit_rev & (~hit_rev + 1'b1);
    assign below_first = first_hit - 1'b1;
    assign en_mask     = (is_walk && i_item.stop_at_first) ? below_first : '1;
    assign sel         = i_item.stop_at_first ? first_hit : last_hit;

    genvar g;
    generate
        for (g = 0; g < SLOTS_MAX; g++) begin : g_slot
            if (g < SLOTS) begin : g_act
                t_slot_ctl ctl;
                assign ctl.action    = i_item.action;
                assign ctl.is_writer = (i_item.writer_slot == 5'(g));
                assign ctl.en        = en_mask[g];

                rsvu_slot u_slot (
                    .i_state   (i_item.states_in[2*g +: 2]),
                    .i_ctl     (ctl),
                    .i_map     (map),
                    .i_table   (i_item.report_table),
                    .o_state   (states[2*g +: 2]),
                    .o_code    (code[g]),
                    .o_changed (chg[g]),
                    .o_demote  (dem[g])
                );
                assign hit[g] = is_walk && (code[g] != 2'd0);
            end else begin : g_pass
                assign states[2*g +: 2] = i_item.states_in[2*g +: 2];
                assign code[g]          = 2'd0;
                assign chg[g]           = 1'b0;
                assign dem[g]           = 1'b0;
                assign hit[g]           = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        report = 2'd0;
        for (int k = 0; k < SLOTS_MAX; k++) begin
            report = report | ({2{sel[k]}} & code[k]);
        end
    end

    assign o_result.states_out  = states;
    assign o_result.report_code = report;
    assign o_result.changed     = |chg;
    assign o_result.gen_bump    = !is_walk && (|dem);

endmodule

@@ hdl/replica_state_vector_update_unit.sv @@
// Top level of the replica state vector update unit.
`timescale 1ns / 1ps
// Usage: raise start with an item on i_item; the item transfers at any rising edge
// where start is high and busy is low. busy never rises, so one item can transfer
// in every cycle with no gaps.
// Each item yields exactly one result on o_result, marked by o_strobe for one
// cycle. The receiver has no way to hold a result off and must take it then.
// The item is captured in an input register, all slots are rewritten in parallel
// by one level of slot logic, and the result register drives the outputs. Throughput
// is one item per cycle, set by the single register-to-register pass through the
// slot logic.
// STATE_BYTES selects how many slots (four per byte) are rewritten; the higher
// slots of the vector pass through unchanged.
// Synchronous reset clears the item and result strobes, so no result is issued
// for an item in flight at reset. The unit keeps no state between items.
module replica_state_vector_update_unit #(
    parameter int STATE_BYTES = rsvu_pkg::STATE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rsvu_pkg::t_item   i_item,
    output logic              o_strobe,
    output rsvu_pkg::t_result o_result
);
    import rsvu_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_item   r_item;
    logic    r_strobe;
    t_result r_result;
    t_result n_result;

    assign busy    = 1'b0;
    assign n_valid = start && !busy;

    rsvu_core #(
        .STATE_BYTES (STATE_BYTES)
    ) u_core (
        .i_item   (r_item),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_strobe <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_item <= i_item;
        end
        if (r_valid) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_transfer_to_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe)
        else $error("Accepted transfer did not produce a result strobe.");

    a_no_spurious_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_valid))
        else $error("Result strobe without a captured item.");

    a_bump_only_mark : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.gen_bump) |-> (o_result.report_code == 2'd0))
        else $error("Generation bump raised together with a walk report.");

    a_unchanged_vector : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.changed) |-> (o_result.states_out == $past(r_item.states_in)))
        else $error("Vector differs from input while no change was flagged.");

endmodule

@@ dv/tb_replica_state_vector_update_unit.sv @@
// Testbench for the replica state vector update unit with a self-checking scoreboard.
`timescale 1ns / 1ps

class rsvu_scoreboard;
    rsvu_pkg::t_result expected_q[$];
    int                slot_count;
    int                errors;
    int                checked;

    function new(int state_bytes);
        slot_count = state_bytes * 4;
        if (slot_count > rsvu_pkg::SLOTS_MAX) slot_count = rsvu_pkg::SLOTS_MAX;
        errors  = 0;
        checked = 0;
    endfunction

    function rsvu_pkg::t_result predict_update(rsvu_pkg::t_item it);
        rsvu_pkg::t_result            r;
        logic [rsvu_pkg::VEC_W-1:0]   v;
        logic [1:0]                   s;
        logic [1:0]                   ns;
        logic [1:0]                   code;
        logic [2:0]                   m;
        logic                         halted;
        r      = '0;
        v      = it.states_in;
        halted = 1'b0;
        for (int i = 0; i < slot_count; i++) begin
            if (!halted) begin
                s  = v[2*i +: 2];
                ns = s;
                if (it.action == rsvu_pkg::ACT_MARK) begin
                    if (i == int'(it.writer_slot)) begin
                        ns = rsvu_pkg::ST_ACTIVE;
                    end else if (s == rsvu_pkg::ST_ACTIVE) begin
                        ns         = rsvu_pkg::ST_OLD;
                        r.gen_bump = 1'b1;
                    end else if (s == rsvu_pkg::ST_OLD) begin
                        ns = rsvu_pkg::ST_TOO_OLD;
                    end
                end else begin
                    code = it.report_table[2*s +: 2];
                    case (s)
                        rsvu_pkg::ST_INACTIVE: m = it.map_inactive;
                        rsvu_pkg::ST_OLD:      m = it.map_old;
                        rsvu_pkg::ST_TOO_OLD:  m = it.map_too_old;
                        default:               m = it.map_active;
                    endcase
                    if (code != 2'd0) begin
                        r.report_code = code;
                        if (it.stop_at_first) halted = 1'b1;
                    end
                    if (!halted && m < 3'd4) ns = m[1:0];
                end
                if (ns != s) begin
                    r.changed    = 1'b1;
                    v[2*i +: 2]  = ns;
                end
            end
        end
        r.states_out = v;
        return r;
    endfunction

    function void note_item(rsvu_pkg::t_item it);
        expected_q.push_back(predict_update(it));
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(rsvu_pkg::t_result got);
        rsvu_pkg::t_result want;
        if (expected_q.size() == 0) begin
            report_mismatch("result with no pending expectation");
        end else begin
            want = expected_q.pop_front();
            checked++;
            if (got.states_out !== want.states_out)
                report_mismatch($sformatf("states_out got %h want %h",
                                          got.states_out, want.states_out));
            if (got.report_code !== want.report_code)
                report_mismatch($sformatf("report_code got %0d want %0d",
                                          got.report_code, want.report_code));
            if (got.changed !== want.changed)
                report_mismatch($sformatf("changed got %b want %b",
                                          got.changed, want.changed));
            if (got.gen_bump !== want.gen_bump)
                report_mismatch($sformatf("gen_bump got %b want %b",
                                          got.gen_bump, want.gen_bump));
        end
    endtask
endclass

module tb_replica_state_vector_update_unit;
    import rsvu_pkg::*;

    localparam int         DUT_STATE_BYTES = STATE_BYTES_DEF;
    localparam int         RANDOM_ITEMS    = 1800;
    localparam int         QUIET_TAIL      = 300;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam logic [2:0] MAP_KEEP        = 3'd4;
    localparam logic [2:0] MAP_KEEP_MAX    = 3'd7;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_strobe;
    t_result o_result;

    rsvu_scoreboard sb;
    int             cycle_count;
    int             mark_count;
    int             walk_count;
    int             stop_count;

    replica_state_vector_update_unit #(
        .STATE_BYTES(DUT_STATE_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Note each transfer before checking, so a same-cycle result would still line up.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_item(i_item);
            if (o_strobe) sb.check_result(o_result);
        end
    end

    function automatic t_item build_item(logic act, logic [VEC_W-1:0] states,
                                         logic [4:0] writer, logic [2:0] mi,
                                         logic [2:0] mo, logic [2:0] mt,
                                         logic [2:0] ma, logic [7:0] tbl,
                                         logic stop);
        t_item it;
        it.action        = act;
        it.states_in     = states;
        it.writer_slot   = writer;
        it.map_inactive  = mi;
        it.map_old       = mo;
        it.map_too_old   = mt;
        it.map_active    = ma;
        it.report_table  = tbl;
        it.stop_at_first = stop;
        return it;
    endfunction

    function automatic logic [VEC_W-1:0] random_states();
        logic [VEC_W-1:0] v;
        logic [1:0]       fill;
        int               kind;
        kind = $urandom_range(0, 3);
        v    = {$urandom, $urandom};
        if (kind == 1) begin
            fill = 2'($urandom_range(0, 3));
            v    = {SLOTS_MAX{fill}};
        end else if (kind == 2) begin
            fill = 2'($urandom_range(0, 3));
            v    = {SLOTS_MAX{fill}};
            repeat ($urandom_range(1, 4)) v[2*$urandom_range(0, SLOTS_MAX-1) +: 2] = 2'($urandom);
        end
        return v;
    endfunction

    function automatic logic [2:0] random_map();
        if ($urandom_range(0, 9) < 7) return 3'($urandom_range(0, 4));
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic t_item random_item();
        t_item      it;
        logic [7:0] tbl;
        tbl = 8'($urandom);
        // Sparse report tables make a stopped walk land somewhere inside the vector.
        if ($urandom_range(0, 2) == 0) begin
            tbl = '0;
            tbl[2*$urandom_range(0, 3) +: 2] = 2'($urandom_range(1, 3));
        end
        it = build_item(1'($urandom), random_states(), 5'($urandom),
                        random_map(), random_map(), random_map(), random_map(),
                        tbl, 1'($urandom));
        return it;
    endfunction

    task automatic send_item(input t_item it);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        if (it.action == ACT_MARK) mark_count++;
        else walk_count++;
        if (it.action == ACT_WALK && it.stop_at_first) stop_count++;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_burst(input int cycles);
        @(negedge i_clk);
        start  <= 1'b0;
        i_item <= random_item();
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic run_directed();
        logic [VEC_W-1:0] ones;
        logic [VEC_W-1:0] olds;
        logic [VEC_W-1:0] too_olds;
        logic [VEC_W-1:0] lone_active;
        ones        = '1;
        olds        = {SLOTS_MAX{ST_OLD}};
        too_olds    = {SLOTS_MAX{ST_TOO_OLD}};
        lone_active = '0;
        lone_active[2*7 +: 2] = ST_ACTIVE;
        send_item(build_item(ACT_MARK, '0, 5'd0, 3'd0, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0));
        send_item(build_item(ACT_MARK, ones, 5'd31, 3'd0, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0));
        send_item(build_item(ACT_MARK, ones, 5'd0, 3'd0, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0));
        send_item(build_item(ACT_MARK, olds, 5'd5, 3'd0, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0));
        send_item(build_item(ACT_MARK, too_olds, 5'd0, 3'd0, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0));
        send_item(build_item(ACT_MARK, lone_active, 5'd7, 3'd0, 3'd0, 3'd0, 3'd0,
                             8'h00, 1'b0));
        send_item(build_item(ACT_MARK, {$urandom, $urandom}, 5'd16, '1, '1, '1, '1,
                             8'hFF, 1'b1));
        send_item(build_item(ACT_WALK, {$urandom, $urandom}, 5'd3, MAP_KEEP, MAP_KEEP,
                             MAP_KEEP, MAP_KEEP, 8'h00, 1'b0));
        send_item(build_item(ACT_WALK, {$urandom, $urandom}, 5'd3, MAP_KEEP_MAX, 3'd6,
                             3'd5, MAP_KEEP_MAX, 8'h00, 1'b0));
        send_item(build_item(ACT_WALK, {$urandom, $urandom}, 5'd0, 3'd0, 3'd1, 3'd2,
                             3'd3, 8'h00, 1'b0));
        send_item(build_item(ACT_WALK, {$urandom, $urandom}, 5'd0, 3'd3, 3'd2, 3'd1,
                             3'd0, 8'h00, 1'b0));
        send_item(build_item(ACT_WALK, {$urandom, $urandom}, 5'd0, 3'd0, 3'd0, 3'd0,
                             3'd0, 8'hFF, 1'b0));
        send_item(build_item(ACT_WALK, {$urandom, $urandom}, 5'd0, 3'd0, 3'd0, 3'd0,
                             3'd0, 8'hFF, 1'b1));
        send_item(build_item(ACT_WALK, lone_active << 6, 5'd0, 3'd1, 3'd2, 3'd3, 3'd0,
                             8'hC0, 1'b1));
        send_item(build_item(ACT_WALK, lone_active << 6, 5'd0, 3'd1, 3'd2, 3'd3, 3'd0,
                             8'hC0, 1'b0));
        send_item(build_item(ACT_WALK, '0, 5'd0, 3'd2, 3'd0, 3'd0, 3'd0, 8'h24, 1'b1));
        send_item(build_item(ACT_WALK, '0, 5'd0, 3'd3, 3'd3, 3'd3, 3'd3, 8'h00, 1'b0));
        send_item(build_item(ACT_WALK, ones, 5'd0, 3'd0, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0));
        send_item(build_item(ACT_WALK, ones, 5'd31, '1, '1, '1, '1, 8'hFF, 1'b1));
        send_item(build_item(ACT_WALK, olds, 5'd31, '1, 3'd2, '1, '1, 8'h10, 1'b1));
    endtask

    initial begin
        sb          = new(DUT_STATE_BYTES);
        cycle_count = 0;
        mark_count  = 0;
        walk_count  = 0;
        stop_count  = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
                idle_burst($urandom_range(1, 8));
            send_item(random_item());
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) sb.report_mismatch("expectations left at end of run");

        $display("Covered %0d mark-writer and %0d walk transfers, %0d walks with stop-at-first.",
                 mark_count, walk_count, stop_count);
        $display("Checked %0d results against the predicted vectors.", sb.checked);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
